/* src/time_of_day_alarm_table_core_macros.svh */
// Assertion helpers shared by the alarm table RTL.
`ifndef TIME_OF_DAY_ALARM_TABLE_CORE_MACROS_SVH
`define TIME_OF_DAY_ALARM_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TDAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TDAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tdat_pkg.sv */
`timescale 1ns / 1ps

package tdat_pkg;

  localparam int SecsW = 17;
  localparam int TagW  = 8;

  localparam logic [4:0] MaxHour   = 5'd23;
  localparam logic [5:0] MaxMinute = 6'd59;
  localparam logic [5:0] MaxSecond = 6'd59;

  localparam logic OpSet  = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef logic [2:0] kind_t;

  localparam kind_t KindAccepted   = 3'd0;
  localparam kind_t KindBadHours   = 3'd1;
  localparam kind_t KindBadMinutes = 3'd2;
  localparam kind_t KindBadSeconds = 3'd3;
  localparam kind_t KindFull       = 3'd4;
  localparam kind_t KindFired      = 3'd5;
  localparam kind_t KindNone       = 3'd6;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [SecsW-1:0] secs;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [SecsW-1:0] secs;
  } decode_t;

endpackage

/* src/tdat_decode.sv */
`timescale 1ns / 1ps

module tdat_decode
  import tdat_pkg::*;
(
  input  logic [4:0] hour_value,
  input  logic [5:0] minute_value,
  input  logic [5:0] second_value,
  input  logic       full,
  output decode_t    dec
);

  // Form seconds of the day; out-of-range fields still fit in 17 bits.
  always_comb begin
    dec.secs = SecsW'(hour_value) * SecsW'(3600)
             + SecsW'(minute_value) * SecsW'(60)
             + SecsW'(second_value);
    priority if (hour_value > MaxHour) begin
      dec.kind = KindBadHours;
    end else if (minute_value > MaxMinute) begin
      dec.kind = KindBadMinutes;
    end else if (second_value > MaxSecond) begin
      dec.kind = KindBadSeconds;
    end else if (full) begin
      dec.kind = KindFull;
    end else begin
      dec.kind = KindAccepted;
    end
  end

endmodule

/* src/time_of_day_alarm_table_core.sv */
`timescale 1ns / 1ps
// Time-of-day alarm table.
// Input beats (s_*): s_tuser is the opcode (0 set, 1 tick); s_tdata carries
// hour, minute, second and tag. A set checks the fields and appends the alarm;
// a tick carries the current time and fires every stored alarm at or before it.
// Output beats (m_*): m_tuser is the result kind, m_tdata the fired tag,
// m_tlast marks the final result of one input beat.
// A tick scans the N stored alarms in the table memory, one entry read per
// cycle through its single registered read port unless a stall holds the
// scan. Survivors are written back compacted in the same pass through the
// write port.
// One input beat is worked on at a time; s_tready is high only when idle, and
// a new beat is taken while the previous result still sits in the output
// register. When the receiver stalls and a further fire needs the output
// register, the scan holds on its entry until that frees up; no result is lost.
// Reset (synchronous, rst high) empties the table and drops any pending
// output; the table memory itself needs no clearing pass, since only entries
// below the fill count are ever used.
`include "time_of_day_alarm_table_core_macros.svh"

module time_of_day_alarm_table_core
  import tdat_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [4:0] hour_value, [10:5] minute_value,
                                // [16:11] second_value, [24:17] alarm_tag
  input  logic        s_tuser,  // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] fired_tag
  output logic [2:0]  m_tuser,  // [2:0] result_kind
  output logic        m_tlast   // last_result
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SET   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  // Table memory: tag and time of day per entry.
  entry_t mem [SLOTS];
  entry_t rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic [1:0]       state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    rd;
  logic [CW-1:0]    wr;
  logic [CW-1:0]    rd_inc;
  logic             pend;
  logic [TagW-1:0]  pend_tag;
  logic [SecsW-1:0] now_secs;
  logic [TagW-1:0]  tag_reg;
  kind_t            set_kind;
  logic             m_tvalid_next;

  decode_t dec;
  logic    in_beat;
  logic    out_free;
  logic    fire;
  logic    step;

  tdat_decode u_decode (
    .hour_value   (s_tdata[4:0]),
    .minute_value (s_tdata[10:5]),
    .second_value (s_tdata[16:11]),
    .full         (count == SlotsC),
    .dec          (dec)
  );

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_inc   = rd + CW'(1);
  assign fire     = (rd_data.secs <= now_secs);
  // A fire with an earlier fire still held must push that one out first.
  assign step     = !(fire && pend) || out_free;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = wr[IW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_CHECK: begin
        rd_addr = step ? rd_inc[IW-1:0] : rd[IW-1:0];
        wr_en   = !fire;
      end
      S_SET: begin
        wr_en   = out_free && (set_kind == KindAccepted);
        wr_addr = count[IW-1:0];
        wr_data = '{tag: tag_reg, secs: now_secs};
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Drop the output beat once taken; load a new one where a result leaves.
  always_comb begin
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_SET, S_FINAL: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
        end
      end
      S_CHECK: begin
        if (step && fire && pend) begin
          m_tvalid_next = 1'b1;
        end
      end
      default: begin
        m_tvalid_next = m_tvalid && !m_tready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd       <= '0;
      wr       <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            now_secs <= dec.secs;
            tag_reg  <= s_tdata[24:17];
            set_kind <= dec.kind;
            rd       <= '0;
            wr       <= '0;
            pend     <= 1'b0;
            if (s_tuser == OpSet) begin
              state <= S_SET;
            end else if (count == '0) begin
              state <= S_FINAL;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SET: begin
          if (out_free) begin
            m_tuser  <= set_kind;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            if (set_kind == KindAccepted) begin
              count <= count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (step) begin
            if (fire) begin
              // Hold the newest fire; emit the older one as a non-final beat.
              if (pend) begin
                m_tuser  <= KindFired;
                m_tdata  <= pend_tag;
                m_tlast  <= 1'b0;
              end
              pend     <= 1'b1;
              pend_tag <= rd_data.tag;
            end else begin
              wr <= wr + CW'(1);
            end
            rd <= rd_inc;
            if (rd_inc == count) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            m_tuser  <= pend ? KindFired : KindNone;
            m_tdata  <= pend ? pend_tag : '0;
            m_tlast  <= 1'b1;
            count    <= wr;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TDAT_ASSERT_NOW(a_count_bound, 1'b1, count <= SlotsC, "fill count above table size")
  `TDAT_ASSERT_NOW(a_wr_behind_rd, state == S_CHECK, wr <= rd && rd < count,
                   "compaction write pointer passed read pointer")
  `TDAT_ASSERT_NOW(a_none_is_last, m_tvalid && m_tuser == KindNone, m_tlast && m_tdata == '0,
                   "none-fired result not final")
  `TDAT_ASSERT_NEXT(a_final_count, state == S_FINAL && out_free, count == $past(wr),
                    "fill count not updated from survivors")

endmodule
